>>> sv/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; imported by every module of the block.
package mi3_pkg;

   localparam int NUM_ELEM = 9;
   localparam int ROW_LEN  = 3;

   // Pipeline control handed from the top level to every stage group
   typedef struct packed {
      logic advance;
   } pipe_ctrl_type;

endpackage

>>> sv/mi3_cofactor.sv
// Cofactor stages: 18 element products, then the nine 2x2 differences.
// Depends on mi3_pkg.
module mi3_cofactor import mi3_pkg::*; #(
   parameter int EW = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pipe_ctrl_type                  ctrl,
   input  logic                           in_valid,
   input  logic [NUM_ELEM*EW-1:0]         mat,
   output logic                           out_valid,
   output logic [NUM_ELEM*(2*EW+1)-1:0]   adj,
   output logic [ROW_LEN*EW-1:0]          row0
);

   localparam int PW = 2 * EW;
   localparam int CW = 2 * EW + 1;
   localparam int NPROD = 2 * NUM_ELEM;

   // Operand pairs: cofactor k is product 2k minus product 2k+1
   localparam int OPA [NPROD] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
   localparam int OPB [NPROD] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};

   logic signed [PW-1:0]  prod_ff [NPROD];
   logic signed [CW-1:0]  cof_ff  [NUM_ELEM];
   logic [ROW_LEN*EW-1:0] row_s1_ff, row_s2_ff;
   logic                  v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (ctrl.advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   for (genvar p = 0; p < NPROD; p++) begin : g_prod
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            prod_ff[p] <= $signed(mat[OPA[p]*EW +: EW]) * $signed(mat[OPB[p]*EW +: EW]);
         end
      end
   end

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_cof
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            cof_ff[k] <= CW'(prod_ff[2*k]) - CW'(prod_ff[2*k+1]);
         end
      end
      assign adj[k*CW +: CW] = cof_ff[k];
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         row_s1_ff <= mat[ROW_LEN*EW-1:0];
         row_s2_ff <= row_s1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign row0      = row_s2_ff;

endmodule

>>> sv/mi3_det.sv
// Determinant stages: first-row expansion as split partial products,
// recombined terms and the final three-term sum. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; #(
   parameter int EW = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pipe_ctrl_type                  ctrl,
   input  logic                           in_valid,
   input  logic [NUM_ELEM*(2*EW+1)-1:0]   adj,
   input  logic [ROW_LEN*EW-1:0]          row0,
   output logic                           out_valid,
   output logic signed [3*EW+2:0]         det,
   output logic [NUM_ELEM*(2*EW+1)-1:0]   adj_out
);

   localparam int CW = 2 * EW + 1;
   localparam int DW = 3 * EW + 3;

   logic signed [CW-1:0]  plo_ff  [ROW_LEN];
   logic signed [CW-1:0]  phi_ff  [ROW_LEN];
   logic signed [DW-1:0]  term_ff [ROW_LEN];
   logic signed [DW-1:0]  det_ff;
   logic [NUM_ELEM*CW-1:0] adj1_ff, adj2_ff, adj3_ff;
   logic                  v1_ff, v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ctrl.advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Split cofactors 0, 3 and 6 into an unsigned low half and a signed high half
   for (genvar t = 0; t < ROW_LEN; t++) begin : g_term
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            plo_ff[t]  <= $signed(row0[t*EW +: EW])
                          * $signed({1'b0, adj[t*ROW_LEN*CW +: EW]});
            phi_ff[t]  <= $signed(row0[t*EW +: EW])
                          * $signed(adj[t*ROW_LEN*CW + EW +: EW+1]);
            term_ff[t] <= (DW'(phi_ff[t]) <<< EW) + DW'(plo_ff[t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         adj1_ff <= adj;
         adj2_ff <= adj1_ff;
         adj3_ff <= adj2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign det       = det_ff;
   assign adj_out   = adj3_ff;

endmodule

>>> sv/mi3_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// Depends on mi3_pkg for the pipeline control type.
module mi3_div import mi3_pkg::*; #(
   parameter int EW = 24,
   parameter int NW = 73,
   parameter int DW = 75
) (
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic          neg,
   output logic [EW-1:0] quot,
   output logic          ovf,
   output logic          quot_neg
);

   localparam int CW = (NW > DW + EW) ? NW : DW + EW;

   logic [CW-1:0] rem_ff [EW+1];
   logic [DW-1:0] den_ff [EW+1];
   logic [EW-1:0] q_ff   [EW+1];
   logic          ovf_ff [EW+1];
   logic          neg_ff [EW+1];

   // Quotient of 2^EW or more saturates in any case
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rem_ff[0] <= CW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= CW'(num) >= (CW'(den) << EW);
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 1; k <= EW; k++) begin : g_step
      logic [CW:0] trial;
      assign trial = {1'b0, rem_ff[k-1]} - ({1'b0, CW'(den_ff[k-1])} << (EW - k));
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            rem_ff[k] <= trial[CW] ? rem_ff[k-1] : trial[CW-1:0];
            q_ff[k]   <= q_ff[k-1] | (EW'(!trial[CW]) << (EW - k));
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign quot     = q_ff[EW];
   assign ovf      = ovf_ff[EW];
   assign quot_neg = neg_ff[EW];

endmodule

>>> sv/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate in signed fixed point.
// Throughput one matrix per cycle while the output is not stalled.
// Depth is set by the divider, which resolves one quotient bit per stage.
// A stalled output holds the whole pipeline; reset clears all valid bits only.
// Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_div.
module matrix3x3_inverse import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = 24,
   parameter int FRAC_BITS  = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up, zero padded
   input  logic [((NUM_ELEM*ELEM_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inv00 .. inv22, det_out from bit 0 up, zero padded
   output logic [(((NUM_ELEM+1)*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular
   output logic rsp_tuser
);

   localparam int EW = ELEM_WIDTH;
   localparam int CW = 2 * EW + 1;
   localparam int DW = 3 * EW + 3;
   localparam int SH = 2 * FRAC_BITS;
   localparam int NW = CW + SH;
   localparam int OW = (((NUM_ELEM+1)*EW+7)/8)*8;
   localparam logic [EW-1:0] MAXPOS = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] MINNEG = {1'b1, {(EW-1){1'b0}}};

   pipe_ctrl_type ctrl;
   logic          out_valid_ff;

   assign ctrl.advance = !out_valid_ff || rsp_tready;
   assign req_tready   = ctrl.advance;

   logic                  cof_valid, det_valid;
   logic [NUM_ELEM*CW-1:0] cof_adj, det_adj;
   logic [3*EW-1:0]       row0;
   logic signed [DW-1:0]  det;

   mi3_cofactor #(.EW(EW)) u_cof (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_valid  (req_tvalid),
      .mat       (req_tdata[NUM_ELEM*EW-1:0]),
      .out_valid (cof_valid),
      .adj       (cof_adj),
      .row0      (row0)
   );

   mi3_det #(.EW(EW)) u_det (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_valid  (cof_valid),
      .adj       (cof_adj),
      .row0      (row0),
      .out_valid (det_valid),
      .det       (det),
      .adj_out   (det_adj)
   );

   // Prepare divider operands, singular flag and the rescaled determinant
   logic signed [DW-1:0] det_sh;
   logic [EW-1:0]        det_sat_in;
   logic [DW-1:0]        dmag_ff;
   logic [NW-1:0]        num_ff [NUM_ELEM];
   logic                 qneg_ff [NUM_ELEM];

   assign det_sh = det >>> SH;

   always_comb begin
      if (det_sh > $signed({{(DW-EW){1'b0}}, MAXPOS})) begin
         det_sat_in = MAXPOS;
      end else if (det_sh < $signed({{(DW-EW){1'b1}}, MINNEG})) begin
         det_sat_in = MINNEG;
      end else begin
         det_sat_in = det_sh[EW-1:0];
      end
   end

   // Delay line for determinant output and singular flag, matched to the divider
   logic [EW-1:0] dout_ff [EW+2];
   logic          sing_ff [EW+2];
   logic          vline_ff [EW+2];
   logic [EW-1:0] dout_out_ff;
   logic          sing_out_ff;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         dmag_ff    <= det[DW-1] ? DW'(-det) : DW'(det);
         dout_ff[0] <= det_sat_in;
         sing_ff[0] <= (det == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vline_ff[0] <= 1'b0;
      end else if (ctrl.advance) begin
         vline_ff[0] <= det_valid;
      end
   end

   for (genvar s = 1; s <= EW + 1; s++) begin : g_line
      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            dout_ff[s] <= dout_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vline_ff[s] <= 1'b0;
         end else if (ctrl.advance) begin
            vline_ff[s] <= vline_ff[s-1];
         end
      end
   end

   logic [EW-1:0] inv_ff [NUM_ELEM];

   for (genvar k = 0; k < NUM_ELEM; k++) begin : g_elem
      logic signed [CW-1:0] a;
      logic [EW-1:0]        quot;
      logic                 ovf, qneg;
      logic [EW-1:0]        sat_in;

      assign a = $signed(det_adj[k*CW +: CW]);

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            num_ff[k]  <= NW'(a[CW-1] ? CW'(-a) : CW'(a)) << SH;
            qneg_ff[k] <= a[CW-1] ^ det[DW-1];
         end
      end

      mi3_div #(.EW(EW), .NW(NW), .DW(DW)) u_div (
         .clock    (clock),
         .ctrl     (ctrl),
         .num      (num_ff[k]),
         .den      (dmag_ff),
         .neg      (qneg_ff[k]),
         .quot     (quot),
         .ovf      (ovf),
         .quot_neg (qneg)
      );

      always_comb begin
         if (sing_ff[EW+1]) begin
            sat_in = '0;
         end else if (qneg) begin
            sat_in = (ovf || quot > MINNEG) ? MINNEG : EW'(-quot);
         end else begin
            sat_in = (ovf || quot[EW-1]) ? MAXPOS : quot;
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.advance) begin
            inv_ff[k] <= sat_in;
         end
      end

      assign rsp_tdata[k*EW +: EW] = inv_ff[k];
   end

   // Output register: last stage of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         out_valid_ff <= vline_ff[EW+1];
      end
   end

   // Register determinant and flag alongside the inverse elements
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         dout_out_ff <= dout_ff[EW+1];
         sing_out_ff <= sing_ff[EW+1];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata[NUM_ELEM*EW +: EW] = dout_out_ff;
   assign rsp_tuser = sing_out_ff;

   if (OW > (NUM_ELEM + 1) * EW) begin : g_pad
      assign rsp_tdata[OW-1:(NUM_ELEM+1)*EW] = '0;
   end

endmodule

>>> tb/matrix3x3_inverse_checker.sv
// Checker for matrix3x3_inverse: watches both stream channels, predicts each inverse
// in wide signed arithmetic and compares every field. Depends on mi3_pkg only.
module matrix3x3_inverse_checker import mi3_pkg::*; #(
   parameter int ELEM_WIDTH = 24,
   parameter int FRAC_BITS  = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [NUM_ELEM*ELEM_WIDTH-1:0] req_tdata,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [(NUM_ELEM+1)*ELEM_WIDTH-1:0] rsp_tdata,
   input  logic rsp_tuser,
   output int   errors,
   output int   outstanding,
   output int   checked,
   output int   singular_seen
);

   typedef struct packed {
      logic [NUM_ELEM:0][ELEM_WIDTH-1:0] words;  // inv00 .. inv22, det_out
      logic                              singular;
   } inverse_type;

   inverse_type inverse_q[$];

   function automatic logic [ELEM_WIDTH-1:0] clamp_elem(logic neg, logic [127:0] mag);
      logic [127:0] lim;
      lim = 128'(1) << (ELEM_WIDTH - 1);
      if (neg) begin
         if (mag > lim) return lim[ELEM_WIDTH-1:0];
         return ELEM_WIDTH'(-mag);
      end
      if (mag > lim - 1) return ELEM_WIDTH'(lim - 1);
      return mag[ELEM_WIDTH-1:0];
   endfunction

   function automatic inverse_type predict_inverse(logic [NUM_ELEM-1:0][ELEM_WIDTH-1:0] m);
      logic signed [95:0] a [NUM_ELEM];
      logic signed [95:0] cof [NUM_ELEM];
      logic signed [95:0] det;
      logic signed [95:0] shifted;
      logic [127:0] num;
      logic [127:0] dmag;
      inverse_type r;
      for (int i = 0; i < NUM_ELEM; i++) a[i] = $signed(m[i]);
      cof[0] = a[4] * a[8] - a[7] * a[5];
      cof[1] = a[2] * a[7] - a[1] * a[8];
      cof[2] = a[1] * a[5] - a[2] * a[4];
      cof[3] = a[5] * a[6] - a[3] * a[8];
      cof[4] = a[0] * a[8] - a[2] * a[6];
      cof[5] = a[3] * a[2] - a[0] * a[5];
      cof[6] = a[3] * a[7] - a[6] * a[4];
      cof[7] = a[6] * a[1] - a[0] * a[7];
      cof[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      dmag = (det < 0) ? -det : det;
      for (int i = 0; i < NUM_ELEM; i++) begin
         num = (cof[i] < 0) ? -cof[i] : cof[i];
         num = num << (2 * FRAC_BITS);
         r.words[i] = clamp_elem((cof[i] < 0) != (det < 0), num / dmag);
      end
      // floor shift back to Q.FRAC_BITS
      shifted = det >>> (2 * FRAC_BITS);
      r.words[NUM_ELEM] = (shifted < 0) ? clamp_elem(1'b1, -shifted)
                                        : clamp_elem(1'b0, shifted);
      return r;
   endfunction

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   initial begin
      errors        = 0;
      outstanding   = 0;
      checked       = 0;
      singular_seen = 0;
   end

   always @(posedge clock) begin
      inverse_type want;
      inverse_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) inverse_q.push_back(predict_inverse(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.words    = rsp_tdata;
            got.singular = rsp_tuser;
            if (inverse_q.size() == 0) begin
               report("result transaction with no matrix outstanding");
            end else begin
               want = inverse_q.pop_front();
               checked++;
               if (want.singular) singular_seen++;
               for (int i = 0; i <= NUM_ELEM; i++)
                  if (got.words[i] !== want.words[i])
                     report($sformatf("result %0d field %0d: got %h want %h",
                                      checked, i, got.words[i], want.words[i]));
               if (got.singular !== want.singular)
                  report($sformatf("result %0d singular: got %b want %b",
                                   checked, got.singular, want.singular));
            end
         end
         outstanding = inverse_q.size();
      end
   end

endmodule

>>> tb/tb_matrix3x3_inverse.sv
// Top of the matrix3x3_inverse testbench: clock, reset, stimulus and verdict.
// Depends on mi3_pkg, matrix3x3_inverse and matrix3x3_inverse_checker.
module tb_matrix3x3_inverse import mi3_pkg::*;;

   localparam int EW  = 24;
   localparam int FB  = 12;
   localparam int ONE = 1 << FB;

   typedef logic [NUM_ELEM-1:0][EW-1:0] matrix_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   matrix_type req_tdata;  // a00 .. a22 from bit 0 up
   logic rsp_tvalid;
   logic rsp_tready;
   logic [(NUM_ELEM+1)*EW-1:0] rsp_tdata;  // inv00 .. inv22, det_out from bit 0 up
   logic rsp_tuser;  // singular

   int errors, outstanding, checked, singular_seen;
   int send_idle_pct, recv_idle_pct;

   matrix3x3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) i_dut (.*);

   matrix3x3_inverse_checker #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) i_checker (.*);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_matrix(matrix_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [EW-1:0] rand_elem(int mag);
      return EW'($urandom_range(2 * mag) - mag);
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      int kind;
      kind = $urandom_range(99);
      for (int i = 0; i < NUM_ELEM; i++) begin
         if (kind < 40) m[i] = rand_elem(1 << ($urandom_range(14, 4)));
         else if (kind < 75) m[i] = EW'($urandom);
         else m[i] = (i % 4 == 0) ? EW'(ONE + $urandom_range(511) - 256)
                                  : rand_elem(300);
      end
      // force a rank deficiency now and then
      if (kind >= 88) begin
         for (int c = 0; c < ROW_LEN; c++) m[2*ROW_LEN+c] = m[c];
         if (kind >= 94) for (int r = 0; r < ROW_LEN; r++) m[r*ROW_LEN+1] = '0;
      end
      return m;
   endfunction

   function automatic matrix_type diag(int d0, int d1, int d2);
      matrix_type m;
      m = '0;
      m[0] = EW'(d0);
      m[4] = EW'(d1);
      m[8] = EW'(d2);
      return m;
   endfunction

   task automatic run_directed();
      matrix_type m;
      send_matrix(diag(ONE, ONE, ONE));
      send_matrix('0);
      send_matrix(diag(2 * ONE, -ONE, ONE / 2));
      send_matrix(diag(1, 1, 1));                  // tiny det, inverse saturates high
      send_matrix(diag(-1, 1, 1));                 // inv00 saturates low, inv11 and inv22 high
      send_matrix(diag(ONE, ONE, 0));              // singular by a zero pivot
      for (int i = 0; i < NUM_ELEM; i++) m[i] = {1'b0, {(EW-1){1'b1}}};
      send_matrix(m);                              // all max, singular
      send_matrix(diag(8388607, 8388607, 8388607)); // det_out saturates high
      send_matrix(diag(-8388608, 8388607, 8388607)); // det_out saturates low
      send_matrix(diag(-8388608, -8388608, -8388608));
      m = diag(-ONE, ONE, ONE);
      m[1] = EW'(3 * ONE);
      m[5] = EW'(-2 * ONE);
      m[6] = EW'(ONE / 4);
      send_matrix(m);
      for (int i = 0; i < NUM_ELEM; i++) m[i] = (i % 2) ? '1 : {1'b1, {(EW-1){1'b0}}};
      send_matrix(m);
      m = diag(ONE, ONE, ONE);
      m[2] = EW'(8388607);
      m[6] = EW'(-8388608);
      send_matrix(m);
      send_matrix(diag(3, 5, 7));                  // inexact quotients truncate
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 48;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 48;
            recv_idle_pct = 17;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 530; n++) send_matrix(random_matrix());
      end
      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      repeat (64) @(posedge clock);
      $display("checked %0d inverses, %0d of them singular, under three handshake mixes",
               checked, singular_seen);
      if (errors == 0) begin
         $display("PASS matrix3x3_inverse");
      end else begin
         $display("FAIL matrix3x3_inverse");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d results outstanding", outstanding);
      $display("FAIL matrix3x3_inverse");
      $finish;
   end

endmodule

>>> filelist.f
sv/mi3_pkg.sv
sv/mi3_cofactor.sv
sv/mi3_det.sv
sv/mi3_div.sv
sv/matrix3x3_inverse.sv
tb/matrix3x3_inverse_checker.sv
tb/tb_matrix3x3_inverse.sv
